// File: rtl/rcppm_pkg.sv
// Shared types and constants for the PPM capture and regenerate unit.
// No dependencies.
package rcppm_pkg;

   localparam int VAL_W  = 16;
   localparam int CHAN_W = 4;
   localparam int CSR_W  = 2;

   localparam logic [VAL_W-1:0] VAL_MAX = '1;

   // configuration register indexes
   localparam logic [CSR_W-1:0] CSR_SYNC_THRESHOLD = 2'd0;
   localparam logic [CSR_W-1:0] CSR_PAUSE_TICKS    = 2'd1;
   localparam logic [CSR_W-1:0] CSR_FRAME_TICKS    = 2'd2;

   localparam logic [VAL_W-1:0] SYNC_THRESHOLD_RST = 16'd3000;
   localparam logic [VAL_W-1:0] PAUSE_TICKS_RST    = 16'd300;
   localparam logic [VAL_W-1:0] FRAME_TICKS_RST    = 16'd22500;
   localparam logic [VAL_W-1:0] COUNTDOWN_RST      = 16'd100;

   // one stored channel width, as seen this tick
   typedef struct packed {
      logic              strobe;
      logic [CHAN_W-1:0] channel;
      logic [VAL_W-1:0]  width;
   } capture_type;

endpackage

// File: rtl/rcppm_decoder.sv
// PPM input decoder: falling edge interval timer and channel index.
// Depends on rcppm_pkg.
module rcppm_decoder #(
   parameter int CHANNELS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        level,
   input  logic [rcppm_pkg::VAL_W-1:0] sync_threshold,
   output rcppm_pkg::capture_type      capture,
   output logic                        sync_seen
);

   localparam int CNT_W = $clog2(CHANNELS + 1);
   localparam int CW    = rcppm_pkg::CHAN_W;
   localparam int VW    = rcppm_pkg::VAL_W;

   logic             prev_ff, prev_in;
   logic [VW-1:0]    count_ff, count_in;
   logic [CNT_W-1:0] index_ff, index_in;
   logic [VW-1:0]    count_inc;
   logic             fall;

   always_comb begin
      count_inc = (count_ff == rcppm_pkg::VAL_MAX) ? count_ff : count_ff + VW'(1);
      fall      = prev_ff & ~level;
      prev_in   = level;
      count_in  = count_inc;
      index_in  = index_ff;
      capture   = '0;
      sync_seen = 1'b0;
      if (fall) begin
         count_in = '0;
         if (count_inc >= sync_threshold) begin
            index_in  = '0;
            sync_seen = 1'b1;
         end else if (index_ff < CNT_W'(CHANNELS)) begin
            capture.strobe  = 1'b1;
            capture.channel = CW'(index_ff);
            capture.width   = count_inc;
            index_in        = index_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b0;
         count_ff <= '0;
         index_ff <= '0;
      end else if (step) begin
         prev_ff  <= prev_in;
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

endmodule

// File: rtl/rcppm_generator.sv
// PPM output generator: channel width store, pulse/gap countdown and frame fill.
// Depends on rcppm_pkg.
module rcppm_generator #(
   parameter int CHANNELS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  rcppm_pkg::capture_type      capture,
   input  logic [rcppm_pkg::VAL_W-1:0] pause_ticks,
   input  logic [rcppm_pkg::VAL_W-1:0] frame_ticks,
   output logic                        out_level
);

   localparam int CNT_W = $clog2(CHANNELS + 1);
   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int VW    = rcppm_pkg::VAL_W;
   localparam int CW    = rcppm_pkg::CHAN_W;

   logic [VW-1:0]    width_ff [CHANNELS];
   logic [VW-1:0]    cd_ff, cd_in;
   logic             pulse_ff, pulse_in;
   logic [CNT_W-1:0] gidx_ff, gidx_in;
   logic [VW-1:0]    elapsed_ff, elapsed_in;
   logic             out_ff, out_in;
   logic [VW-1:0]    elapsed_inc, chan_width, sub_a, sub_b;
   logic [VW-1:0]    diff;
   logic [VW-1:0]    load;
   logic             from_capture;

   always_comb begin
      elapsed_inc = (elapsed_ff == rcppm_pkg::VAL_MAX) ? elapsed_ff
                                                       : elapsed_ff + VW'(1);
      // this tick's capture lands before the generator reads the store
      from_capture = capture.strobe && (capture.channel == CW'(gidx_ff));
      chan_width   = from_capture ? capture.width : width_ff[gidx_ff[IDX_W-1:0]];

      if (pulse_ff) begin
         sub_a = pause_ticks;
         sub_b = '0;
      end else if (gidx_ff < CNT_W'(CHANNELS)) begin
         sub_a = chan_width;
         sub_b = pause_ticks;
      end else begin
         sub_a = frame_ticks;
         sub_b = elapsed_inc;
      end
      diff = sub_a - sub_b;
      load = (sub_a <= sub_b) ? VW'(1) : diff;

      cd_in      = cd_ff - VW'(1);
      pulse_in   = pulse_ff;
      gidx_in    = gidx_ff;
      elapsed_in = elapsed_inc;
      out_in     = out_ff;
      if (cd_ff <= VW'(1)) begin
         cd_in    = load;
         pulse_in = ~pulse_ff;
         out_in   = ~pulse_ff;
         if (!pulse_ff) begin
            if (gidx_ff < CNT_W'(CHANNELS)) begin
               gidx_in = gidx_ff + CNT_W'(1);
            end else begin
               gidx_in    = '0;
               elapsed_in = '0;
            end
         end
      end
      out_level = out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_ff      <= rcppm_pkg::COUNTDOWN_RST;
         pulse_ff   <= 1'b1;
         gidx_ff    <= '0;
         elapsed_ff <= '0;
         out_ff     <= 1'b1;
         for (int i = 0; i < CHANNELS; i++) begin
            width_ff[i] <= '0;
         end
      end else if (step) begin
         cd_ff      <= cd_in;
         pulse_ff   <= pulse_in;
         gidx_ff    <= gidx_in;
         elapsed_ff <= elapsed_in;
         out_ff     <= out_in;
         if (capture.strobe) begin
            width_ff[capture.channel[IDX_W-1:0]] <= capture.width;
         end
      end
   end

endmodule

// File: rtl/rc_ppm_capture_and_regenerate_unit.sv
// Top level of the PPM capture and regenerate unit: channels, settings, result register.
// Depends on rcppm_pkg, rcppm_decoder and rcppm_generator.
//
//   channel  direction  ports                                       word
//   req      in         req_valid/ready, req_ppm_level              one tick of input line
//   rsp      out        rsp_valid/ready, rsp_out_level, rsp_capture_*,
//                       rsp_sync_seen                                one tick of results
//   csr      in         csr_valid/ready, csr_index, csr_data        one register write
//
// One word per cycle unless rsp stalls: a tick is accepted whenever the result register is
// empty or being emptied in the same cycle, and its result reaches that register next cycle.
// The whole tick update (decoder, width store, countdown) is one pass of combinational
// logic from the state registers into the result register. Reset returns the settings,
// decoder and generator state (not the result word) to power-on values; the width store
// is cleared at once. A stalled rsp holds its word and stops further req acceptance.
module rc_ppm_capture_and_regenerate_unit #(
   parameter int CHANNELS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_ppm_level,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_out_level,
   output logic                        rsp_capture_strobe,
   output logic [rcppm_pkg::CHAN_W-1:0] rsp_capture_channel,
   output logic [rcppm_pkg::VAL_W-1:0] rsp_capture_width,
   output logic                        rsp_sync_seen,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rcppm_pkg::CSR_W-1:0] csr_index,
   input  logic [rcppm_pkg::VAL_W-1:0] csr_data
);

   logic [rcppm_pkg::VAL_W-1:0] sync_thr_ff, pause_ff, frame_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        level_ff, level_in;
   rcppm_pkg::capture_type      cap_ff, cap_in;
   logic                        sync_ff, sync_in;
   logic                        step;

   assign csr_ready = 1'b1;
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign step      = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_thr_ff <= rcppm_pkg::SYNC_THRESHOLD_RST;
         pause_ff    <= rcppm_pkg::PAUSE_TICKS_RST;
         frame_ff    <= rcppm_pkg::FRAME_TICKS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            rcppm_pkg::CSR_SYNC_THRESHOLD: sync_thr_ff <= csr_data;
            rcppm_pkg::CSR_PAUSE_TICKS:    pause_ff    <= csr_data;
            rcppm_pkg::CSR_FRAME_TICKS:    frame_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   rcppm_decoder #(.CHANNELS(CHANNELS)) u_decoder (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .level          (req_ppm_level),
      .sync_threshold (sync_thr_ff),
      .capture        (cap_in),
      .sync_seen      (sync_in)
   );

   rcppm_generator #(.CHANNELS(CHANNELS)) u_generator (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .capture     (cap_in),
      .pause_ticks (pause_ff),
      .frame_ticks (frame_ff),
      .out_level   (level_in)
   );

   assign rsp_valid_in = step | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         level_ff <= level_in;
         cap_ff   <= cap_in;
         sync_ff  <= sync_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_level       = level_ff;
   assign rsp_capture_strobe  = cap_ff.strobe;
   assign rsp_capture_channel = cap_ff.channel;
   assign rsp_capture_width   = cap_ff.width;
   assign rsp_sync_seen       = sync_ff;

endmodule

// File: rtl/rcppm_checker.sv
// Port-level checks for the PPM capture and regenerate unit, bound to its top level.
// Depends on rcppm_pkg and rc_ppm_capture_and_regenerate_unit.
module rcppm_checker #(
   parameter int CHANNELS = 8
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_capture_strobe,
   input logic [rcppm_pkg::CHAN_W-1:0] rsp_capture_channel,
   input logic [rcppm_pkg::VAL_W-1:0]  rsp_capture_width,
   input logic                         rsp_sync_seen
);

   // a result word is never dropped while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // every accepted tick produces a word in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted tick produced no result");

   // a sync interval never stores a channel
   a_sync_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_capture_strobe && rsp_sync_seen))
      else $error("capture and sync in one word");

   // capture fields are zero without a strobe, and in range with one
   a_capture_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_capture_strobe ?
         (32'(rsp_capture_channel) < CHANNELS) && (rsp_capture_width != '0) :
         (rsp_capture_channel == '0) && (rsp_capture_width == '0)))
      else $error("capture fields inconsistent");

endmodule

bind rc_ppm_capture_and_regenerate_unit rcppm_checker #(.CHANNELS(CHANNELS)) u_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_capture_strobe  (rsp_capture_strobe),
   .rsp_capture_channel (rsp_capture_channel),
   .rsp_capture_width   (rsp_capture_width),
   .rsp_sync_seen       (rsp_sync_seen)
);
